// File: hdl/pfrs_pkg.sv
// Package for the page framebuffer region scroll block.
// Holds item kind codes, register indexes, reset values and the sequencer state type.
// No dependencies.
package pfrs_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_SCROLL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_TOP    = 2'd2,
        REG_BOTTOM = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    localparam logic [7:0] LEFT_RESET   = 8'd0;
    localparam logic [7:0] RIGHT_RESET  = 8'd128;
    localparam logic [5:0] TOP_RESET    = 6'd0;
    localparam logic [6:0] BOTTOM_RESET = 7'd64;

endpackage

// File: hdl/pfrs_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
// Used for the frame store; no package dependencies.
module pfrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/page_framebuffer_region_scroll.sv
// Top level of the page-organized monochrome frame store with region scroll.
// Depends on pfrs_pkg (codes, types) and pfrs_ram (frame store memory).
//
// Usage notes.
// The input channel (in_valid, in_stall and the fields kind, column, page,
// write_data) carries one item per handshake: a byte write, a byte read or a
// scroll of the configured rectangle up by one line. The output channel
// (out_valid, out_stall, read_data, scroll_done) returns one item for each
// read and each scroll; writes and the unused kind return nothing.
// A byte write is stored at the edge that accepts it. A byte read holds the
// input while the frame store memory answers; its result is loaded into the
// output register at the clock edge after the one that accepts it.
// A scroll walks the region column by column through the single read port of
// the memory: for each column it reads every page touched, then a flush step
// writes back the last page. A scroll holds the input until the walk and a
// final drain state are through; its result is loaded as the drain state
// ends. An empty region does not stall the input; its result is loaded at
// the edge that accepts it.
// After reset the block runs a clearing pass that writes zero to every byte;
// input stays stalled during it, while configuration writes are taken as
// usual.
// When the receiver stalls, the finished result waits in the output register
// and the input is stalled too; the next item can be accepted at the edge at
// which the receiver takes the result.
module page_framebuffer_region_scroll #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [6:0]  column,
    input  logic [2:0]  page,
    input  logic [7:0]  write_data,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        scroll_done
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int LINES = PAGES * 8;
    localparam int LW    = ($clog2(LINES + 1) > 7) ? $clog2(LINES + 1) : 7;
    localparam int LW1   = LW + 1;

    // Configuration registers.
    logic [7:0] left_column_reg;
    logic [7:0] right_column_reg;
    logic [5:0] top_line_reg;
    logic [6:0] bottom_line_reg;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_column_reg  <= pfrs_pkg::LEFT_RESET;
            right_column_reg <= pfrs_pkg::RIGHT_RESET;
            top_line_reg     <= pfrs_pkg::TOP_RESET;
            bottom_line_reg  <= pfrs_pkg::BOTTOM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                pfrs_pkg::REG_LEFT:   left_column_reg  <= pwdata[7:0];
                pfrs_pkg::REG_RIGHT:  right_column_reg <= pwdata[7:0];
                pfrs_pkg::REG_TOP:    top_line_reg     <= pwdata[5:0];
                pfrs_pkg::REG_BOTTOM: bottom_line_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pfrs_pkg::REG_LEFT:   prdata = 32'(left_column_reg);
            pfrs_pkg::REG_RIGHT:  prdata = 32'(right_column_reg);
            pfrs_pkg::REG_TOP:    prdata = 32'(top_line_reg);
            pfrs_pkg::REG_BOTTOM: prdata = 32'(bottom_line_reg);
            default:              prdata = 32'd0;
        endcase
    end

    // The region, clamped to the store. Columns are compared at nine bits so
    // that a store of 256 columns still fits.
    logic [8:0]    right_clamp;
    logic [LW-1:0] bottom_clamp;
    logic          region_empty;
    logic [PW-1:0] top_page;
    logic [PW-1:0] bottom_page;

    always_comb
    begin
        right_clamp  = (9'(right_column_reg) > 9'(COLUMNS)) ? 9'(COLUMNS)
                                                            : 9'(right_column_reg);
        bottom_clamp = (LW'(bottom_line_reg) > LW'(LINES)) ? LW'(LINES)
                                                           : LW'(bottom_line_reg);
        region_empty = (9'(left_column_reg) >= right_clamp)
                    || (LW'(top_line_reg) >= bottom_clamp);
        top_page     = PW'(LW'(top_line_reg) >> 3);
        bottom_page  = PW'((bottom_clamp - LW'(1)) >> 3);
    end

    // Control and pipeline registers.
    pfrs_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [CW-1:0] sc_col_reg, sc_col_next;
    logic [PW-1:0] sc_pg_reg, sc_pg_next;
    logic          sc_flush_reg, sc_flush_next;
    // Second stage of the scroll walk: the read issued in the cycle before.
    logic          s2_valid_reg, s2_valid_next;
    logic          s2_flush_reg, s2_flush_next;
    logic [PW-1:0] s2_pg_reg, s2_pg_next;
    logic [CW-1:0] s2_col_reg, s2_col_next;
    logic [7:0]    prev_reg, prev_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_done_reg, out_done_next;

    // Memory port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          in_accept;
    logic          host_ok;
    logic [AW-1:0] host_addr;
    logic          out_free;

    // Write-back of one scrolled byte.
    logic [PW-1:0] wb_pg;
    logic          wb_next_bit;
    logic [7:0]    shift_mask;
    logic [7:0]    clear_mask;
    logic [7:0]    wb_byte;
    logic [LW1-1:0] bit_line;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != pfrs_pkg::ST_IDLE) || rd_pend_reg || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign host_ok   = (9'(column) < 9'(COLUMNS)) && (5'(page) < 5'(PAGES));
    assign host_addr = AW'(int'(page) * COLUMNS + int'(column));

    // A byte of page p takes each bit from the line below inside the region;
    // bit 7 takes bit 0 of the next page, and the last region line is cleared.
    always_comb
    begin
        wb_pg       = s2_flush_reg ? bottom_page : PW'(s2_pg_reg - PW'(1));
        wb_next_bit = s2_flush_reg ? 1'b0 : ram_rdata[0];
        for (int b = 0; b < 8; b++)
        begin
            bit_line      = LW1'({wb_pg, 3'(b)});
            shift_mask[b] = (bit_line >= LW1'(top_line_reg))
                         && (bit_line + LW1'(1) < LW1'(bottom_clamp));
            clear_mask[b] = (bit_line + LW1'(1) == LW1'(bottom_clamp));
        end
        wb_byte = (prev_reg & ~(shift_mask | clear_mask))
                | ({wb_next_bit, prev_reg[7:1]} & shift_mask);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_pend_next   = 1'b0;
        rd_ok_next     = rd_ok_reg;
        sc_col_next    = sc_col_reg;
        sc_pg_next     = sc_pg_reg;
        sc_flush_next  = sc_flush_reg;
        s2_valid_next  = 1'b0;
        s2_flush_next  = s2_flush_reg;
        s2_pg_next     = s2_pg_reg;
        s2_col_next    = s2_col_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        out_done_next  = out_done_reg;
        ram_we         = 1'b0;
        ram_waddr      = host_addr;
        ram_wdata      = write_data;
        ram_raddr      = host_addr;

        // Host read completes: the memory answers in the cycle after the address.
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rd_ok_reg ? ram_rdata : 8'd0;
            out_done_next  = 1'b0;
        end

        // Second stage of the scroll walk.
        if (s2_valid_reg)
        begin
            if (!s2_flush_reg)
            begin
                prev_next = ram_rdata;
            end
            if (s2_flush_reg || (s2_pg_reg != top_page))
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(int'(wb_pg) * COLUMNS + int'(s2_col_reg));
                ram_wdata = wb_byte;
            end
        end

        unique case (state_reg)
            pfrs_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = 8'd0;
                clr_cnt_next = AW'(clr_cnt_reg + AW'(1));
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = pfrs_pkg::ST_IDLE;
                end
            end
            pfrs_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (kind == pfrs_pkg::KIND_WRITE)
                    begin
                        ram_we = host_ok;
                    end
                    else if (kind == pfrs_pkg::KIND_READ)
                    begin
                        rd_pend_next = 1'b1;
                        rd_ok_next   = host_ok;
                    end
                    else if (kind == pfrs_pkg::KIND_SCROLL)
                    begin
                        if (region_empty)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = 8'd0;
                            out_done_next  = 1'b1;
                        end
                        else
                        begin
                            state_next    = pfrs_pkg::ST_SCAN;
                            sc_col_next   = CW'(left_column_reg);
                            sc_pg_next    = top_page;
                            sc_flush_next = 1'b0;
                        end
                    end
                end
            end
            pfrs_pkg::ST_SCAN:
            begin
                s2_valid_next = 1'b1;
                s2_flush_next = sc_flush_reg;
                s2_pg_next    = sc_pg_reg;
                s2_col_next   = sc_col_reg;
                ram_raddr     = AW'(int'(sc_pg_reg) * COLUMNS + int'(sc_col_reg));
                if (!sc_flush_reg)
                begin
                    if (sc_pg_reg == bottom_page)
                    begin
                        sc_flush_next = 1'b1;
                    end
                    else
                    begin
                        sc_pg_next = PW'(sc_pg_reg + PW'(1));
                    end
                end
                else if (9'(sc_col_reg) + 9'd1 == right_clamp)
                begin
                    state_next = pfrs_pkg::ST_DRAIN;
                end
                else
                begin
                    sc_col_next   = CW'(sc_col_reg + CW'(1));
                    sc_pg_next    = top_page;
                    sc_flush_next = 1'b0;
                end
            end
            pfrs_pkg::ST_DRAIN:
            begin
                // The last write-back happens at this edge.
                state_next     = pfrs_pkg::ST_IDLE;
                out_valid_next = 1'b1;
                out_data_next  = 8'd0;
                out_done_next  = 1'b1;
            end
            default:
            begin
                state_next = pfrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfrs_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            sc_flush_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            sc_flush_reg  <= sc_flush_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ok_reg    <= rd_ok_next;
        sc_col_reg   <= sc_col_next;
        sc_pg_reg    <= sc_pg_next;
        s2_flush_reg <= s2_flush_next;
        s2_pg_reg    <= s2_pg_next;
        s2_col_reg   <= s2_col_next;
        prev_reg     <= prev_next;
        out_data_reg <= out_data_next;
        out_done_reg <= out_done_next;
    end

    pfrs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign read_data   = out_data_reg;
    assign scroll_done = out_done_reg;

`ifndef SYNTHESIS
    // A pending host read always finds the output register empty.
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !out_valid_reg)
        else $error("host read completes into a full output register");

    // Scroll write-back only runs while the walk or its drain is active.
    a_s2_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (state_reg == pfrs_pkg::ST_SCAN || state_reg == pfrs_pkg::ST_DRAIN))
        else $error("scroll write-back outside a scroll");

    // The output register stays empty during a scroll walk.
    a_scan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfrs_pkg::ST_SCAN) |-> !out_valid_reg)
        else $error("output register busy during scroll");
`endif

endmodule

// File: verif/tb.sv
// Self-checking testbench for the page framebuffer region scroll block.
// Depends on pfrs_pkg for the item kind codes, register indexes and reset values,
// and on page_framebuffer_region_scroll as the device under test.
module tb;

    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;
    localparam int LINES   = PAGES * 8;

    // Kind 3 is not decoded by the block; it must be swallowed without a result.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Cycles allowed after the last result before the block counts as idle.
    // A byte write that gives no result may still be finishing at that point.
    localparam int SETTLE_CYCLES = 8;

    // Longest quiet stretch on both channels: the clearing pass after reset or a
    // full-store scroll, plus a receiver stall. The limit is several times the
    // worst of those.
    localparam int WATCHDOG_LIMIT = 6000;

    localparam int RANDOM_PHASES = 20;
    localparam int OPS_PER_PHASE = 65;
    localparam int QUIET_PHASES  = 3;

    typedef struct {
        logic [1:0] kind;
        logic [6:0] column;
        logic [2:0] page;
        logic [7:0] wdata;
        bit         drain_first;   // hold this item back until every result is in
    } host_op_t;

    typedef struct {
        logic [7:0] byte_val;
        logic       scroll_flag;
    } reply_t;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic [6:0]  column = '0;
    logic [2:0]  page = '0;
    logic [7:0]  write_data = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data;
    logic        scroll_done;

    page_framebuffer_region_scroll #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .column      (column),
        .page        (page),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .scroll_done (scroll_done)
    );

    // Shadow copy of the frame store and of the scroll region registers.
    logic [7:0] fb_shadow [0:COLUMNS*PAGES-1];
    int region_left   = pfrs_pkg::LEFT_RESET;
    int region_right  = pfrs_pkg::RIGHT_RESET;
    int region_top    = pfrs_pkg::TOP_RESET;
    int region_bottom = pfrs_pkg::BOTTOM_RESET;

    host_op_t ops_q[$];        // items waiting to be offered to the block
    reply_t   replies_due[$];  // results the block still owes, oldest first
    host_op_t cur_op;          // item currently presented on the input ports

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int stall_run = 0;

    int fail_count = 0;
    int items_taken = 0;
    int replies_seen = 0;
    int writes_taken = 0;
    int reads_checked = 0;
    int scrolls_checked = 0;
    int regions_set = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Frame store prediction. Line L of column C is bit L mod 8 of the byte
    // at page L / 8, so a scroll is done line by line on single pixels. This
    // keeps partial pages, regions inside one page and a bottom line that
    // lands on bit 0 of a page free of any special handling.
    // ------------------------------------------------------------------
    function automatic logic pix_at(int col, int line);
        return fb_shadow[(line / 8) * COLUMNS + col][line % 8];
    endfunction

    function automatic void pix_put(int col, int line, logic v);
        fb_shadow[(line / 8) * COLUMNS + col][line % 8] = v;
    endfunction

    function automatic void region_scroll_up();
        int r_edge;
        int b_edge;
        // Registers may point past the store; the block clamps them.
        r_edge = (region_right > COLUMNS) ? COLUMNS : region_right;
        b_edge = (region_bottom > LINES) ? LINES : region_bottom;
        if (region_left >= r_edge || region_top >= b_edge)
            return;
        for (int x = region_left; x < r_edge; x++) begin
            for (int y = region_top; y + 1 < b_edge; y++)
                pix_put(x, y, pix_at(x, y + 1));
            pix_put(x, b_edge - 1, 1'b0);
        end
    endfunction

    // Applies one accepted item to the shadow store and queues its result.
    function automatic void model_take(host_op_t op);
        reply_t r;
        int idx;
        idx = int'(op.page) * COLUMNS + int'(op.column);
        items_taken++;
        case (op.kind)
            pfrs_pkg::KIND_WRITE: begin
                fb_shadow[idx] = op.wdata;
                writes_taken++;
            end
            pfrs_pkg::KIND_READ: begin
                r.byte_val    = fb_shadow[idx];
                r.scroll_flag = 1'b0;
                replies_due.push_back(r);
            end
            pfrs_pkg::KIND_SCROLL: begin
                region_scroll_up();
                r.byte_val    = 8'h00;
                r.scroll_flag = 1'b1;
                replies_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver. A presented item is held, payload unchanged, until it is
    // taken. Between items the sender may drop valid for a burst of idle
    // cycles, and an item marked drain_first waits until no result is owed.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        host_op_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                model_take(cur_op);
            if (!(in_valid && in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (ops_q.size() != 0 &&
                             (!ops_q[0].drain_first || replies_due.size() == 0)) begin
                    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
                        // This cycle counts as the first of the idle burst.
                        send_gap = $urandom_range(16);
                        in_valid <= 1'b0;
                    end else begin
                        nxt = ops_q.pop_front();
                        cur_op = nxt;
                        in_valid   <= 1'b1;
                        kind       <= nxt.kind;
                        column     <= nxt.column;
                        page       <= nxt.page;
                        write_data <= nxt.wdata;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor and stall generator. Each result taken is matched
    // against the oldest outstanding prediction.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        reply_t want;
        if (rst_n && out_valid && !out_stall) begin
            replies_seen++;
            if (replies_due.size() == 0) begin
                $display("%0t: result with nothing outstanding, read_data %02h scroll_done %0b",
                         $time, read_data, scroll_done);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                if (read_data !== want.byte_val) begin
                    $display("%0t: read_data mismatch, expected %02h, actual %02h",
                             $time, want.byte_val, read_data);
                    fail_count++;
                end
                if (scroll_done !== want.scroll_flag) begin
                    $display("%0t: scroll_done mismatch, expected %0b, actual %0b",
                             $time, want.scroll_flag, scroll_done);
                    fail_count++;
                end
                if (want.scroll_flag)
                    scrolls_checked++;
                else
                    reads_checked++;
            end
        end
        if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
        end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
            stall_run = $urandom_range(16);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial begin
        int quiet;
        int last_in;
        int last_out;
        quiet = 0;
        last_in = 0;
        last_out = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if (items_taken != last_in || replies_seen != last_out)
                quiet = 0;
            else
                quiet++;
            last_in = items_taken;
            last_out = replies_seen;
        end
        $display("%0t: watchdog expired, %0d results outstanding", $time, replies_due.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void push_op(logic [1:0] k, int col, int pg, logic [7:0] d,
                                    bit drain = 1'b0);
        host_op_t op;
        op.kind        = k;
        op.column      = col[6:0];
        op.page        = pg[2:0];
        op.wdata       = d;
        op.drain_first = drain;
        ops_q.push_back(op);
    endfunction

    // Occasional junk in the unused upper bits of a register write.
    function automatic logic [31:0] upper_noise();
        return ($urandom_range(3) == 0) ? $urandom() : 32'h0;
    endfunction

    task automatic apb_write(input pfrs_pkg::reg_index_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes all four region registers and mirrors them in the prediction.
    task automatic program_region(input int l, input int r, input int t, input int b);
        apb_write(pfrs_pkg::REG_LEFT,   (upper_noise() & ~32'hFF) | (l & 32'hFF));
        region_left = l & 'hFF;
        apb_write(pfrs_pkg::REG_RIGHT,  (upper_noise() & ~32'hFF) | (r & 32'hFF));
        region_right = r & 'hFF;
        apb_write(pfrs_pkg::REG_TOP,    (upper_noise() & ~32'h3F) | (t & 32'h3F));
        region_top = t & 'h3F;
        apb_write(pfrs_pkg::REG_BOTTOM, (upper_noise() & ~32'h7F) | (b & 32'h7F));
        region_bottom = b & 'h7F;
        regions_set++;
    endtask

    // Returns once every queued item is taken and every result is in, then lets
    // the block settle so that a trailing byte write has landed.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (ops_q.size() != 0 || in_valid || replies_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random phase: pick a region, program it, then send a mix of items
    // that mostly lands inside the region so that scroll effects are read back.
    task automatic random_phase(input int n_ops, input bit quiet);
        int l, r, t, b, bc;
        int c_lo, c_hi, p_lo, p_hi, pg, roll, col, pgn;
        logic [1:0] k;
        logic [7:0] d;
        wait_idle();
        case ($urandom_range(9))
            0: begin
                l = 0; r = COLUMNS; t = 0; b = LINES;
            end
            1: begin
                // Registers past the store, clamped by the block.
                l = ($urandom_range(1) == 1) ? 0 : 120;
                r = $urandom_range(129, 255);
                t = ($urandom_range(1) == 1) ? 63 : $urandom_range(0, 20);
                b = $urandom_range(65, 127);
            end
            2: begin
                // Empty region, by columns or by lines.
                if ($urandom_range(1) == 1) begin
                    l = $urandom_range(0, 255);
                    r = $urandom_range(0, l);
                    t = $urandom_range(0, 63);
                    b = $urandom_range(1, 127);
                end else begin
                    l = $urandom_range(0, 120);
                    r = l + $urandom_range(1, 8);
                    t = $urandom_range(1, 63);
                    b = $urandom_range(1, t);
                end
            end
            3: begin
                // Region within a single page.
                pg = $urandom_range(0, PAGES - 1);
                t = pg * 8 + $urandom_range(0, 6);
                b = $urandom_range(t + 1, pg * 8 + 8);
                l = $urandom_range(0, 120);
                r = l + $urandom_range(1, 8);
            end
            default: begin
                l = $urandom_range(0, COLUMNS - 1);
                r = l + $urandom_range(1, 12);
                t = $urandom_range(0, 63);
                b = ($urandom_range(3) == 0) ? $urandom_range(1, 127)
                                             : $urandom_range(t + 1, LINES);
            end
        endcase
        program_region(l, r, t, b);

        if (quiet) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end else begin
            send_idle_pct = 12 * $urandom_range(2);
            recv_idle_pct = 12 * $urandom_range(2);
        end

        c_lo = region_left;
        c_hi = ((region_right > COLUMNS) ? COLUMNS : region_right) - 1;
        if (c_lo > c_hi) begin
            c_lo = 0;
            c_hi = COLUMNS - 1;
        end
        bc = (region_bottom > LINES) ? LINES : region_bottom;
        if (region_top >= bc) begin
            p_lo = 0;
            p_hi = PAGES - 1;
        end else begin
            p_lo = region_top / 8;
            p_hi = (bc - 1) / 8;
        end

        for (int n = 0; n < n_ops; n++) begin
            roll = $urandom_range(99);
            if (roll < 45)
                k = pfrs_pkg::KIND_WRITE;
            else if (roll < 80)
                k = pfrs_pkg::KIND_READ;
            else if (roll < 95)
                k = pfrs_pkg::KIND_SCROLL;
            else
                k = KIND_UNUSED;
            col = ($urandom_range(3) != 0) ? $urandom_range(c_lo, c_hi)
                                           : $urandom_range(0, COLUMNS - 1);
            pgn = ($urandom_range(3) != 0) ? $urandom_range(p_lo, p_hi)
                                           : $urandom_range(0, PAGES - 1);
            case ($urandom_range(7))
                0: d = 8'h00;
                1: d = 8'hFF;
                default: d = 8'($urandom());
            endcase
            push_op(k, col, pgn, d, $urandom_range(49) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        foreach (fb_shadow[i])
            fb_shadow[i] = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block is still in its clearing pass here, which
        // it allows for register writes. First the whole store as the region.
        program_region(pfrs_pkg::LEFT_RESET, pfrs_pkg::RIGHT_RESET,
                       pfrs_pkg::TOP_RESET, pfrs_pkg::BOTTOM_RESET);
        push_op(pfrs_pkg::KIND_WRITE, 0, 0, 8'hFF);
        push_op(pfrs_pkg::KIND_WRITE, COLUMNS - 1, PAGES - 1, 8'hFF);
        push_op(pfrs_pkg::KIND_WRITE, 5, 3, 8'h80);
        push_op(pfrs_pkg::KIND_WRITE, 5, 4, 8'h01);
        push_op(pfrs_pkg::KIND_WRITE, 64, 0, 8'hA5);
        push_op(KIND_UNUSED, COLUMNS - 1, PAGES - 1, 8'h5A);
        push_op(pfrs_pkg::KIND_SCROLL, 0, 0, 8'h00);
        // The sender holds off here until the scroll result has been taken.
        push_op(pfrs_pkg::KIND_READ, 0, 0, 8'h00, 1'b1);
        push_op(pfrs_pkg::KIND_READ, COLUMNS - 1, PAGES - 1, 8'h00);
        push_op(pfrs_pkg::KIND_READ, 5, 3, 8'h00);
        push_op(pfrs_pkg::KIND_READ, 5, 4, 8'h00);

        // A region that lies inside one page.
        wait_idle();
        program_region(5, 6, 26, 30);
        push_op(pfrs_pkg::KIND_WRITE, 5, 3, 8'hFF);
        push_op(pfrs_pkg::KIND_SCROLL, 0, 0, 8'h00);
        push_op(pfrs_pkg::KIND_READ, 5, 3, 8'h00);

        // A bottom line that lands on bit 0 of a page: bit 7 of the page above
        // takes that bit, which is then cleared.
        wait_idle();
        program_region(5, 7, 20, 33);
        push_op(pfrs_pkg::KIND_SCROLL, 0, 0, 8'h00);
        push_op(pfrs_pkg::KIND_READ, 5, 4, 8'h00);
        push_op(pfrs_pkg::KIND_READ, 5, 3, 8'h00);

        // An empty region still returns a scroll result and changes nothing.
        wait_idle();
        program_region(200, 10, 50, 20);
        push_op(pfrs_pkg::KIND_SCROLL, 0, 0, 8'h00);

        // A one-line region ending on a page boundary only clears that line.
        wait_idle();
        program_region(0, 3, 7, 8);
        push_op(pfrs_pkg::KIND_WRITE, 0, 0, 8'hFF);
        push_op(pfrs_pkg::KIND_SCROLL, 0, 0, 8'h00);
        push_op(pfrs_pkg::KIND_READ, 0, 0, 8'h00);

        // Register values past the store, clamped to its edges.
        wait_idle();
        program_region(120, 255, 60, 127);
        push_op(pfrs_pkg::KIND_SCROLL, 0, 0, 8'h00);
        push_op(pfrs_pkg::KIND_READ, COLUMNS - 1, PAGES - 1, 8'h00);

        // Random part; the last phases run with both sides always ready.
        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(OPS_PER_PHASE, p >= RANDOM_PHASES - QUIET_PHASES);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d byte writes, %0d reads and %0d scrolls over %0d region settings.",
                 writes_taken, reads_checked, scrolls_checked, regions_set);
        if (fail_count == 0 && replies_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/pfrs_pkg.sv
hdl/pfrs_ram.sv
hdl/page_framebuffer_region_scroll.sv
verif/tb.sv
